[hdl/ols_pkg.sv]
// shared types and codes for the ordered list store
package ols_pkg;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOCATE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_DELETE = 3'd2,
    CELL_WRITE  = 3'd3,
    CELL_LOAD   = 3'd4,
    CELL_SCAN   = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] key;
  } cell_ctrl_t;

endpackage

[hdl/ols_cmd_if.sv]
// command channel of the ordered list store
interface ols_cmd_if;
  import ols_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, command, position, value, new_value, input ready);
  modport sink   (input valid, command, position, value, new_value, output ready);
endinterface

[hdl/ols_res_if.sv]
// result channel of the ordered list store
interface ols_res_if;
  import ols_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [POS_W-1:0]  found_position;
  logic [POS_W-1:0]  list_length;

  modport source (output valid, status, found, found_position, list_length, input ready);
  modport sink   (input valid, status, found, found_position, list_length, output ready);
endinterface

[hdl/ordered_list_store.sv]
// ordered list store: top level with command sequencer and row of entry cells
//
//   channel | dir | fields
//   --------+-----+------------------------------------------------
//   cmd     | in  | command, position, value, new_value
//   res     | out | status, found, found_position, list_length
//
// insert and delete: accept, then one shift of all cells as the result is registered
// locate and replace: accept, load of the hit flags, k shifts, then the result;
//   k = 0-based index of the first match, or the list length minus one when none
//   (0 for an empty list); the hit flags step one cell a cycle toward the head
// one command at a time; a new command is accepted as soon as the last one has moved
//   into the result register, even while that result still waits
// reset clears the list length and the sequencer; entries need no clearing
// a stalled result holds the sequencer in its final step until the register frees
module ordered_list_store #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst,
  ols_cmd_if.sink    cmd,
  ols_res_if.source  res
);
  import ols_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // captured command
  logic [CMD_W-1:0]         cmd_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] nval_r;

  // list length and search state
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     scan, scan_next;
  logic [CW-1:0]     fpos, fpos_next;
  logic              found_r, found_next;
  logic [STAT_W-1:0] status_r, status_next;

  // result register
  logic              out_valid, out_valid_next;
  logic [STAT_W-1:0] out_status;
  logic              out_found;
  logic [POS_W-1:0]  out_fpos;
  logic [POS_W-1:0]  out_len;

  logic              emit;
  logic [STAT_W-1:0] e_status;
  logic              e_found;
  logic [CW-1:0]     e_fpos;

  cell_ctrl_t    ctrl;
  logic [CW-1:0] target;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic                     cell_hit  [CAPACITY];

  logic          slot_free;
  logic [LW-1:0] pos_l, cnt_l;
  logic [CW-1:0] scan_inc;

  assign cmd.ready = (state == S_IDLE);
  assign slot_free = !out_valid || res.ready;
  assign pos_l     = LW'(pos_r);
  assign cnt_l     = LW'(count);
  assign scan_inc  = scan + CW'(1);

  // sequencer
  always_comb begin
    state_next  = state;
    count_next  = count;
    scan_next   = scan;
    fpos_next   = fpos;
    found_next  = found_r;
    status_next = status_r;
    ctrl.op     = CELL_HOLD;
    ctrl.wdata  = val_r;
    ctrl.key    = val_r;
    target      = CW'(pos_r);
    emit        = 1'b0;
    e_status    = ST_OK;
    e_found     = 1'b0;
    e_fpos      = '0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == CMD_LOCATE || cmd_r == CMD_REPLACE) begin
          ctrl.op    = CELL_LOAD;
          scan_next  = '0;
          state_next = S_SCAN;
        end else if (slot_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (cmd_r == CMD_INSERT) begin
            if (pos_l == '0 || pos_l > cnt_l + LW'(1)) begin
              e_status = ST_BAD_POS;
            end else if (count == CW'(CAPACITY)) begin
              e_status = ST_FULL;
            end else begin
              ctrl.op    = CELL_INSERT;
              count_next = count + CW'(1);
            end
          end else begin
            if (pos_l == '0 || pos_l > cnt_l) begin
              e_status = ST_BAD_POS;
            end else begin
              ctrl.op    = CELL_DELETE;
              count_next = count - CW'(1);
            end
          end
        end
      end
      S_SCAN: begin
        if (cell_hit[0]) begin
          found_next  = 1'b1;
          fpos_next   = scan_inc;
          status_next = ST_OK;
          state_next  = S_DONE;
        end else if (scan_inc >= count) begin
          found_next  = 1'b0;
          fpos_next   = '0;
          status_next = ST_NOT_FOUND;
          state_next  = S_DONE;
        end else begin
          ctrl.op   = CELL_SCAN;
          scan_next = scan_inc;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_status   = status_r;
          e_found    = found_r;
          e_fpos     = fpos;
          state_next = S_IDLE;
          if (found_r && cmd_r == CMD_REPLACE) begin
            ctrl.op    = CELL_WRITE;
            ctrl.wdata = nval_r;
            target     = fpos;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (res.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan     <= scan_next;
    fpos     <= fpos_next;
    found_r  <= found_next;
    status_r <= status_next;
    if (cmd.valid && cmd.ready) begin
      cmd_r  <= cmd.command;
      pos_r  <= cmd.position;
      val_r  <= cmd.value;
      nval_r <= cmd.new_value;
    end
    if (emit) begin
      out_status <= e_status;
      out_found  <= e_found;
      out_fpos   <= POS_W'(e_fpos);
      out_len    <= POS_W'(count_next);
    end
  end

  assign res.valid          = out_valid;
  assign res.status         = out_status;
  assign res.found          = out_found;
  assign res.found_position = out_fpos;
  assign res.list_length    = out_len;

  // row of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    logic                     right_h;

    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
      assign right_h = 1'b0;
    end else begin : g_body
      assign right_d = cell_data[g+1];
      assign right_h = cell_hit[g+1];
    end

    ols_cell #(
      .INDEX (g),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .count      (count),
      .target     (target),
      .left_data  (left_d),
      .right_data (right_d),
      .right_hit  (right_h),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

endmodule

[hdl/ols_cell.sv]
// one list entry: shifts with its neighbors, compares, and passes a hit flag down
module ols_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ols_pkg::cell_ctrl_t               ctrl,
  input  logic [CW-1:0]                     count,
  input  logic [CW-1:0]                     target,
  input  logic signed [ols_pkg::DATA_W-1:0] left_data,
  input  logic signed [ols_pkg::DATA_W-1:0] right_data,
  input  logic                              right_hit,
  output logic signed [ols_pkg::DATA_W-1:0] data,
  output logic                              hit
);
  import ols_pkg::*;

  // 1-based position of this cell
  localparam logic [CW-1:0] ORD = CW'(INDEX + 1);

  logic signed [DATA_W-1:0] data_next;
  logic                     hit_next;

  // entry update
  always_comb begin
    data_next = data;
    case (ctrl.op)
      CELL_INSERT: begin
        if (ORD == target) begin
          data_next = ctrl.wdata;
        end else if (ORD > target) begin
          data_next = left_data;
        end
      end
      CELL_DELETE: begin
        if (ORD >= target) begin
          data_next = right_data;
        end
      end
      CELL_WRITE: begin
        if (ORD == target) begin
          data_next = ctrl.wdata;
        end
      end
      default: data_next = data;
    endcase
  end

  // match flag: load from compare, then shift toward the head
  always_comb begin
    hit_next = hit;
    case (ctrl.op)
      CELL_LOAD: hit_next = (ORD <= count) && (data == ctrl.key);
      CELL_SCAN: hit_next = right_hit;
      default:   hit_next = hit;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= hit_next;
    end
  end

endmodule

[hdl/ols_checker.sv]
// port-level checks on the ordered list store result channel, bound to the top level
module ols_checker #(
  parameter int CAPACITY = 16
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [ols_pkg::STAT_W-1:0] status,
  input logic                      found,
  input logic [ols_pkg::POS_W-1:0] found_position,
  input logic [ols_pkg::POS_W-1:0] list_length
);
  import ols_pkg::*;

  // a stalled result keeps its fields
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(found)
      && $stable(found_position) && $stable(list_length))
    else $error("result changed while stalled");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // a miss reports no position
  a_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_NOT_FOUND |-> !found && found_position == '0)
    else $error("miss with a position");

  // a full status only when the list is at capacity
  a_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_FULL |-> list_length == POS_W'(CAPACITY))
    else $error("full status below capacity");

  // a reported position implies a match
  a_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && found_position != '0 |-> found && status == ST_OK)
    else $error("position without a match");

endmodule

bind ordered_list_store ols_checker #(
  .CAPACITY (CAPACITY)
) u_ols_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .status         (res.status),
  .found          (res.found),
  .found_position (res.found_position),
  .list_length    (res.list_length)
);

[tb/ordered_list_store_tb.sv]
// self-checking testbench for the ordered list store: directed table, then random commands
module ordered_list_store_tb;
  import ols_pkg::*;

  localparam int CAPACITY      = 16;
  localparam int DIR_N         = 26;
  localparam int RAND_N        = 1800;
  localparam int QUIET_N       = 300;
  localparam int HOLD_AT       = 400;
  localparam int DRAIN_AT      = 1000;
  localparam int HOLD_CYCLES   = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [POS_W-1:0]  fpos;
    logic [POS_W-1:0]  len;
  } outcome_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
    logic                     fixed;
    outcome_t                 want;
  } cmd_row_t;

  logic clk;
  logic rst;

  ols_cmd_if cmd_ch ();
  ols_res_if res_ch ();

  ordered_list_store #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // directed commands; rows with fixed set carry a hand-written outcome
  cmd_row_t directed_cmds [DIR_N] = '{
    '{CMD_DELETE,  5'd1,  32'sd0, 32'sd0, 1'b1, '{ST_BAD_POS, 1'b0, 5'd0, 5'd0}},
    '{CMD_INSERT,  5'd0,  32'sd5, 32'sd0, 1'b1, '{ST_BAD_POS, 1'b0, 5'd0, 5'd0}},
    '{CMD_INSERT,  5'd2,  32'sd5, 32'sd0, 1'b1, '{ST_BAD_POS, 1'b0, 5'd0, 5'd0}},
    '{CMD_INSERT,  5'd1,  32'sh80000000, 32'sd0, 1'b1, '{ST_OK, 1'b0, 5'd0, 5'd1}},
    '{CMD_INSERT,  5'd2,  32'sh7fffffff, 32'sd0, 1'b1, '{ST_OK, 1'b0, 5'd0, 5'd2}},
    '{CMD_LOCATE,  5'd0,  32'sh7fffffff, 32'sd0, 1'b1, '{ST_OK, 1'b1, 5'd2, 5'd2}},
    '{CMD_REPLACE, 5'd31, 32'sh80000000, -32'sd1, 1'b1, '{ST_OK, 1'b1, 5'd1, 5'd2}},
    '{CMD_LOCATE,  5'd0,  32'sd0, 32'sd0, 1'b1, '{ST_NOT_FOUND, 1'b0, 5'd0, 5'd2}},
    '{CMD_INSERT,  5'd1,  32'sd7, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd4,  32'sd7, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd2,  -32'sd7, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd5,  32'sh55555555, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd3,  32'shaaaaaaaa, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd7,  32'sd1, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd1,  -32'sd2, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd9,  32'sd7, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd10, 32'sd0, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd6,  32'sh0000ffff, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd12, 32'shffff0000, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd13, 32'sd3, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd1,  32'sd7, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd16, 32'sh12345678, 32'sd0, 1'b0, '0},
    '{CMD_INSERT,  5'd17, 32'sd9, 32'sd0, 1'b1, '{ST_FULL, 1'b0, 5'd0, 5'd16}},
    '{CMD_INSERT,  5'd31, 32'sd9, 32'sd0, 1'b1, '{ST_BAD_POS, 1'b0, 5'd0, 5'd16}},
    '{CMD_DELETE,  5'd17, 32'sd0, 32'sd0, 1'b1, '{ST_BAD_POS, 1'b0, 5'd0, 5'd16}},
    '{CMD_DELETE,  5'd16, 32'sd0, 32'sd0, 1'b1, '{ST_OK, 1'b0, 5'd0, 5'd15}}
  };

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len;

  outcome_t pending_outcomes [$];
  int       mismatches;
  int       accepted_cmds;
  int       results_seen;
  int       sent_cmds;
  int       stall_cycles;
  bit       hold_req;
  bit       quiet;

  // apply one command to the shadow list and return its outcome
  function automatic outcome_t apply_list_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] val,
                                                  logic signed [DATA_W-1:0] nval);
    outcome_t o;
    int       hit;
    o   = '0;
    hit = 0;
    o.status = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (pos < 1 || pos > list_len + 1) begin
          o.status = ST_BAD_POS;
        end else if (list_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          for (int i = list_len; i >= pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos-1] = val;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          o.status = ST_BAD_POS;
        end else begin
          for (int i = pos; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      default: begin
        for (int i = 0; i < list_len; i++)
          if (hit == 0 && list_mem[i] == val) hit = i + 1;
        if (hit == 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          o.found = 1'b1;
          o.fpos  = hit[POS_W-1:0];
          if (op == CMD_REPLACE) list_mem[hit-1] = nval;
        end
      end
    endcase
    o.len = list_len[POS_W-1:0];
    return o;
  endfunction

  // random data word; search keys mostly come from the list itself
  function automatic logic signed [DATA_W-1:0] random_operand(bit from_list);
    int pick;
    pick = $urandom_range(9, 0);
    if (from_list && list_len > 0 && pick < 7)
      return list_mem[$urandom_range(list_len - 1, 0)];
    pick = $urandom_range(9, 0);
    if (pick < 5) return $urandom;
    if (pick < 8) return $signed($urandom_range(6, 0)) - 3;
    case ($urandom_range(3, 0))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // present one item and hold it until the block takes it
  task automatic issue_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val, logic signed [DATA_W-1:0] nval);
    @(negedge clk);
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= op;
    cmd_ch.position  <= pos;
    cmd_ch.value     <= val;
    cmd_ch.new_value <= nval;
    do @(posedge clk); while (!cmd_ch.ready);
    sent_cmds++;
  endtask

  // occasional sender gap, skipped in calm stretches
  task automatic idle_gap();
    int n;
    if (((sent_cmds / 150) % 3) != 2 && $urandom_range(9, 0) == 0) begin
      n = $urandom_range(7, 1);
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // check results against the oldest expectation, then predict newly accepted items
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.status, res_ch.found, res_ch.found_position, res_ch.list_length};
        results_seen++;
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result with nothing pending: status=%0d found=%0d pos=%0d len=%0d",
                     got.status, got.found, got.fpos, got.len);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.fpos !== want.fpos || got.len !== want.len) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d mismatch: expected status=%0d found=%0d pos=%0d len=%0d",
                       results_seen, want.status, want.found, want.fpos, want.len);
              $display("  got status=%0d found=%0d pos=%0d len=%0d",
                       got.status, got.found, got.fpos, got.len);
            end
          end
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        want = apply_list_command(cmd_ch.command, cmd_ch.position, cmd_ch.value,
                                  cmd_ch.new_value);
        if (accepted_cmds < DIR_N && directed_cmds[accepted_cmds].fixed)
          want = directed_cmds[accepted_cmds].want;
        pending_outcomes.push_back(want);
        accepted_cmds++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: long hold-off on request, random stall bursts otherwise
  initial begin
    res_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && ((results_seen / 128) % 4) != 3 && $urandom_range(7, 0) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(6, 0)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // command side and end of run
  initial begin
    cmd_row_t                 row;
    logic [CMD_W-1:0]         op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] nval;
    int                       roll;
    bit                       growing;

    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CMD_LOCATE;
    cmd_ch.position  = '0;
    cmd_ch.value     = '0;
    cmd_ch.new_value = '0;
    list_len         = 0;
    mismatches       = 0;
    accepted_cmds    = 0;
    results_seen     = 0;
    sent_cmds        = 0;
    stall_cycles     = 0;
    hold_req         = 1'b0;
    quiet            = 1'b0;
    growing          = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int k = 0; k < DIR_N; k++) begin
      row = directed_cmds[k];
      issue_command(row.command, row.position, row.value, row.new_value);
      idle_gap();
    end

    // random commands, drifting between filling and draining the list
    for (int k = 0; k < RAND_N; k++) begin
      if (k == HOLD_AT) hold_req = 1'b1;
      if (k == DRAIN_AT) begin
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
      end
      if (k == RAND_N - QUIET_N) quiet = 1'b1;

      if (list_len == 0) growing = 1'b1;
      else if (list_len == CAPACITY && $urandom_range(3, 0) == 0) growing = 1'b0;
      else if ($urandom_range(79, 0) == 0) growing = !growing;

      roll = $urandom_range(99, 0);
      if (roll < 55)      op = growing ? CMD_INSERT : CMD_DELETE;
      else if (roll < 70) op = growing ? CMD_DELETE : CMD_INSERT;
      else if (roll < 85) op = CMD_LOCATE;
      else                op = CMD_REPLACE;

      if ($urandom_range(9, 0) == 0)
        pos = POS_W'($urandom_range(31, 0));
      else if (op == CMD_INSERT)
        pos = POS_W'($urandom_range(list_len + 1, 1));
      else if (op == CMD_DELETE && list_len > 0)
        pos = POS_W'($urandom_range(list_len, 1));
      else
        pos = POS_W'($urandom_range(31, 0));

      val  = random_operand(op == CMD_LOCATE || op == CMD_REPLACE);
      nval = random_operand(1'b0);
      issue_command(op, pos, val, nval);
      if (!quiet && !hold_req) idle_gap();
    end

    // drain and let the block settle
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
hdl/ols_pkg.sv
hdl/ols_cmd_if.sv
hdl/ols_res_if.sv
hdl/ols_cell.sv
hdl/ordered_list_store.sv
hdl/ols_checker.sv
tb/ordered_list_store_tb.sv
